### design/xf4_pkg.sv
`default_nettype none
package xf4_pkg;

	localparam int COEF_W        = 32;
	localparam int IDX_W         = 4;
	localparam int VEC_N         = 4;
	localparam int MAT_N         = VEC_N * VEC_N;
	localparam int FRAC_BITS_DEF = 16;

	typedef logic signed [COEF_W-1:0] coef_t;

	localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_XFORM = 1'b1
	} func_t;

	typedef struct packed {
		func_t            func;
		logic [IDX_W-1:0] coef_index;
		coef_t            coef_value;
		coef_t            in_x;
		coef_t            in_y;
		coef_t            in_z;
		coef_t            in_w;
	} cmd_word_t;

	typedef struct packed {
		coef_t out_x;
		coef_t out_y;
		coef_t out_z;
		coef_t out_w;
		logic  saturated;
	} res_word_t;

endpackage
`default_nettype wire

### design/xf4_cmd_if.sv
`default_nettype none
interface xf4_cmd_if;
	logic              valid;
	logic              ready;
	xf4_pkg::cmd_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/xf4_res_if.sv
`default_nettype none
interface xf4_res_if;
	logic              valid;
	logic              ready;
	xf4_pkg::res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/homogeneous_transform_4x4_top.sv
`default_nettype none
// 4x4 matrix times vector in signed fixed point (Q16.16 at the default FRAC_BITS).
// Write words (func = write) store one coefficient, row-major, in the accept cycle
// and give no result; the next word already sees the new value. Transform words
// give one result each and run through a four-stage pipeline: sixteen 32x32
// multipliers, two adder levels with rounding, then a shift and saturate stage
// that is also the output register. One word is taken every cycle while
// cmd.ready is high; a transform word moves through stages s1 to s4, and
// res.valid is the s4 valid flag. Each stage holds its word while the next one
// is full and stalled, so bubbles close up during an output stall.
module homogeneous_transform_4x4_top #(
	parameter int FRAC_BITS = xf4_pkg::FRAC_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	xf4_cmd_if.sink    cmd,
	xf4_res_if.source  res
);
	import xf4_pkg::*;

	localparam int PROD_W = 2 * COEF_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int HI_W   = SUM_W - COEF_W + 1;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

	coef_t matrix_q [MAT_N];
	coef_t vec [VEC_N];

	logic signed [PROD_W-1:0] prod_d  [VEC_N][VEC_N];
	logic signed [PROD_W-1:0] prod_s1 [VEC_N][VEC_N];
	logic signed [PAIR_W-1:0] pair_s2 [VEC_N][2];
	logic signed [SUM_W-1:0]  sum_s3  [VEC_N];
	res_word_t                res_d;
	res_word_t                res_s4;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;
	logic write_acc;

	assign en4 = !valid_s4 || res.ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign cmd.ready = en1;
	assign write_acc = cmd.valid && en1 && (cmd.data.func == FUNC_WRITE);

	assign vec[0] = cmd.data.in_x;
	assign vec[1] = cmd.data.in_y;
	assign vec[2] = cmd.data.in_z;
	assign vec[3] = cmd.data.in_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_N; i++) begin
				matrix_q[i] <= '0;
			end
		end else if (write_acc) begin
			matrix_q[cmd.data.coef_index] <= cmd.data.coef_value;
		end
	end

	// products use the matrix as it stands before this word
	always_comb begin
		for (int r = 0; r < VEC_N; r++) begin
			for (int c = 0; c < VEC_N; c++) begin
				prod_d[r][c] = PROD_W'(matrix_q[r*VEC_N+c]) * PROD_W'(vec[c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= cmd.valid && (cmd.data.func == FUNC_XFORM);
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			prod_s1 <= prod_d;
		end
		if (en2) begin
			for (int r = 0; r < VEC_N; r++) begin
				pair_s2[r][0] <= PAIR_W'(prod_s1[r][0]) + PAIR_W'(prod_s1[r][1]);
				pair_s2[r][1] <= PAIR_W'(prod_s1[r][2]) + PAIR_W'(prod_s1[r][3]);
			end
		end
		if (en3) begin
			for (int r = 0; r < VEC_N; r++) begin
				sum_s3[r] <= SUM_W'(pair_s2[r][0]) + SUM_W'(pair_s2[r][1]) + ROUND_HALF;
			end
		end
		if (en4) begin
			res_s4 <= res_d;
		end
	end

	// shift out the fraction, clip when the upper bits are not a pure sign extension
	always_comb begin
		logic signed [SUM_W-1:0] shf;
		logic [HI_W-1:0]         hi;
		coef_t                   comp [VEC_N];
		logic [VEC_N-1:0]        clip;
		for (int r = 0; r < VEC_N; r++) begin
			shf = sum_s3[r] >>> FRAC_BITS;
			hi  = shf[SUM_W-1:COEF_W-1];
			clip[r] = !((&hi) || !(|hi));
			if (!clip[r]) begin
				comp[r] = shf[COEF_W-1:0];
			end else if (shf[SUM_W-1]) begin
				comp[r] = COEF_MIN;
			end else begin
				comp[r] = COEF_MAX;
			end
		end
		res_d.out_x     = comp[0];
		res_d.out_y     = comp[1];
		res_d.out_z     = comp[2];
		res_d.out_w     = comp[3];
		res_d.saturated = |clip;
	end

	assign res.valid = valid_s4;
	assign res.data  = res_s4;

	a_coef_write: assert property (@(posedge clk) disable iff (!arst_n)
		write_acc |=> matrix_q[$past(cmd.data.coef_index)] == $past(cmd.data.coef_value))
		else $error("coefficient write not stored");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("input stalled with a bubble in the pipeline");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.saturated) |->
			(res.data.out_x == COEF_MAX || res.data.out_x == COEF_MIN ||
			 res.data.out_y == COEF_MAX || res.data.out_y == COEF_MIN ||
			 res.data.out_z == COEF_MAX || res.data.out_z == COEF_MIN ||
			 res.data.out_w == COEF_MAX || res.data.out_w == COEF_MIN))
		else $error("saturated flag without a clipped component");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.data.func == FUNC_WRITE) |=> !valid_s1)
		else $error("write word entered the pipeline");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en4) |=> valid_s3 && valid_s4)
		else $error("stalled word dropped");

endmodule
`default_nettype wire
